@@ hdl/poc_pkg.sv @@
`default_nettype none

package poc_pkg;

  // Width of the reported occurrence count.
  localparam int unsigned MATCH_W = 20;

  // Item kinds on the request channel.
  localparam logic KIND_PATTERN = 1'b0;
  localparam logic KIND_TEXT    = 1'b1;

  // One request on the input channel.
  typedef struct packed {
    logic       kind;
    logic [7:0] symbol;
    logic       last;
  } poc_in_t;

  // One result on the output channel.
  typedef struct packed {
    logic [MATCH_W-1:0] match_count;
    logic               pattern_overflow;
  } poc_out_t;

  // Control that the top level broadcasts to every cell.
  typedef struct packed {
    logic shift;  // a text byte steps through the row
    logic clear;  // drop all partial matches
    logic load;   // a pattern byte is written into the selected cell
  } poc_ctrl_t;

endpackage

`default_nettype wire

@@ hdl/poc_cell.sv @@
`default_nettype none

module poc_cell (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire poc_pkg::poc_ctrl_t ctrl,
  input  wire logic               load_sel,
  input  wire logic [7:0]         symbol,
  input  wire logic               match_prev,
  output logic                    match_r,
  output logic                    match_nxt
);
  import poc_pkg::*;

  logic [7:0] pat_byte_r;

  // This cell extends the neighbor's prefix match by one byte.
  assign match_nxt = match_prev && (symbol == pat_byte_r);

  // Pattern byte held by this cell.
  always_ff @(posedge clk) begin
    if (ctrl.load && load_sel) begin
      pat_byte_r <= symbol;
    end
  end

  // Prefix match flag: the last few text bytes equal the pattern up to this cell.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else if (ctrl.clear) begin
      match_r <= 1'b0;
    end else if (ctrl.shift) begin
      match_r <= match_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hdl/poc_cell_row.sv @@
`default_nettype none

module poc_cell_row #(
  parameter int unsigned MAX_PATTERN = 64,
  localparam int unsigned IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1,
  localparam int unsigned LEN_W = $clog2(MAX_PATTERN + 1)
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire poc_pkg::poc_ctrl_t ctrl,
  input  wire logic [IDX_W-1:0]   load_idx,
  input  wire logic [7:0]         symbol,
  input  wire logic [LEN_W-1:0]   pattern_len,
  output logic                    hit
);
  import poc_pkg::*;

  logic [MAX_PATTERN-1:0] match_r;
  logic [MAX_PATTERN-1:0] match_nxt;
  logic [LEN_W-1:0]       tail_pos;

  // Cell i holds pattern byte i and hands its match flag to cell i+1.
  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
    logic match_prev;
    if (i == 0) begin : g_head
      assign match_prev = 1'b1;
    end else begin : g_link
      assign match_prev = match_r[i-1];
    end

    poc_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .load_sel  (load_idx == IDX_W'(i)),
      .symbol    (symbol),
      .match_prev(match_prev),
      .match_r   (match_r[i]),
      .match_nxt (match_nxt[i])
    );
  end

  // A full match shows at the cell of the final pattern byte; an empty pattern always hits.
  assign tail_pos = pattern_len - LEN_W'(1);
  assign hit = (pattern_len == '0) || match_nxt[tail_pos[IDX_W-1:0]];

endmodule

`default_nettype wire

@@ hdl/pattern_occurrence_counter_core.sv @@
// Pattern occurrence counter.
// Requests arrive on in_valid/in_ready with in_data (kind, symbol, last). Pattern
// bytes (kind 0) are loaded first, the final one marked by last. Text bytes
// (kind 1) then stream through a row of MAX_PATTERN cells, one cell per pattern
// byte, and every position where the newest text bytes equal the pattern adds
// one to a saturating count. The text byte marked last produces one result on
// out_valid/out_ready: the count and the pattern overflow flag; the count then
// restarts while the pattern is kept. A pattern byte after a text starts over.
// Pattern bytes beyond MAX_PATTERN are dropped and flag an overflow (count zero).
// Throughput is one request per cycle unless stalled; the cell row advances by
// one byte per accepted text byte. A result is registered and appears in the
// cycle after the final text byte is accepted. While a result waits on a stalled
// receiver, in_ready is low. Reset (rst_n low, synchronous) clears the pattern
// length, the match flags, the count and out_valid; no clearing pass is needed.
`default_nettype none

module pattern_occurrence_counter_core #(
  parameter int unsigned MAX_PATTERN = 64,
  parameter int unsigned COUNT_WIDTH = 20
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire poc_pkg::poc_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output poc_pkg::poc_out_t     out_data
);
  import poc_pkg::*;

  localparam int unsigned IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int unsigned LEN_W = $clog2(MAX_PATTERN + 1);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PATTERN);

  logic [LEN_W-1:0]       len_r, len_nxt, len_eff;
  logic                   done_r, done_nxt;
  logic                   ovf_r, ovf_nxt;
  logic [COUNT_WIDTH-1:0] count_r, count_nxt, count_plus;
  logic                   out_valid_r, out_valid_nxt;
  poc_out_t               out_data_r, out_data_nxt;

  logic      accept, pat_req, txt_req, new_case, room, hit, inc;
  poc_ctrl_t ctrl;
  logic [63:0] count_wide;

  // Accept while the result slot is free or being drained.
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign pat_req  = accept && (in_data.kind == KIND_PATTERN);
  assign txt_req  = accept && (in_data.kind == KIND_TEXT);
  assign new_case = pat_req && done_r;

  // Pattern length as seen by this request after a possible restart.
  assign len_eff = new_case ? '0 : len_r;
  assign room    = len_eff < LEN_MAX;

  // Broadcast control to the cell row.
  assign ctrl.shift = txt_req;
  assign ctrl.clear = new_case || (txt_req && in_data.last);
  assign ctrl.load  = pat_req && room;

  poc_cell_row #(
    .MAX_PATTERN(MAX_PATTERN)
  ) u_row (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .load_idx   (len_eff[IDX_W-1:0]),
    .symbol     (in_data.symbol),
    .pattern_len(len_r),
    .hit        (hit)
  );

  // Count this text byte unless overflowed or saturated.
  assign inc        = hit && !ovf_r && (count_r != '1);
  assign count_plus = count_r + COUNT_WIDTH'(inc);
  assign count_wide = 64'(count_plus);

  // Next state of pattern bookkeeping, count and result register.
  always_comb begin
    len_nxt       = len_r;
    done_nxt      = done_r;
    ovf_nxt       = ovf_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    if (pat_req) begin
      len_nxt   = room ? (len_eff + LEN_W'(1)) : len_eff;
      ovf_nxt   = (new_case ? 1'b0 : ovf_r) || !room;
      done_nxt  = in_data.last;
      count_nxt = new_case ? '0 : count_r;
    end else if (txt_req) begin
      done_nxt = 1'b1;
      if (in_data.last) begin
        count_nxt                     = '0;
        out_valid_nxt                 = 1'b1;
        out_data_nxt.match_count      = ovf_r ? '0 : count_wide[MATCH_W-1:0];
        out_data_nxt.pattern_overflow = ovf_r;
      end else begin
        count_nxt = count_plus;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      done_r      <= 1'b0;
      ovf_r       <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      done_r      <= done_nxt;
      ovf_r       <= ovf_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // An overflowed pattern never accumulates occurrences.
  a_ovf_no_count: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> (count_r == '0))
    else $error("count nonzero while pattern overflowed");

  // A reported overflow carries a zero count.
  a_ovf_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.pattern_overflow) |-> (out_data_r.match_count == '0))
    else $error("overflow result with nonzero count");

  // The stored pattern length never exceeds the cell count.
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_MAX)
    else $error("pattern length beyond cell row");

  // Reset empties the result slot.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("result pending after reset");

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import poc_pkg::*;

  localparam int unsigned MAX_PAT      = 64;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned RANDOM_ITEMS = 1450;
  // One text that matches at every byte against a one-byte pattern.
  localparam int unsigned DENSE_RUN    = 120;
  // Run limit for about 2000 requests with gaps and stalls.
  localparam int unsigned CYCLE_LIMIT  = 100_000;
  localparam logic [MATCH_W-1:0] COUNT_TOP = '1;

  typedef enum logic [1:0] {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_TOGGLE} rx_mode_e;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  poc_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  poc_out_t out_data;

  pattern_occurrence_counter_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // Counts computed ahead of the block, oldest first.
  poc_out_t expected_tallies[$];

  // Predicted counter state. Byte 0 of each vector holds the newest byte.
  logic [8*MAX_PAT-1:0] pattern_bytes = '0;
  logic [8*MAX_PAT-1:0] recent_text   = '0;
  int unsigned          pattern_len   = 0;
  int unsigned          text_fill     = 0;
  bit                   pattern_closed = 1'b0;
  bit                   pattern_too_long = 1'b0;
  logic [MATCH_W-1:0]   running_tally = '0;

  int unsigned cycle_count    = 0;
  int unsigned mismatch_count = 0;
  int unsigned items_sent     = 0;
  int unsigned burst_left     = 0;
  bit          steady         = 1'b0;
  bit          hold_request   = 1'b0;
  bit          hold_off;
  rx_mode_e    ready_mode     = RX_OPEN;
  int unsigned mode_left      = 0;
  bit          ready_now;

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d counts outstanding", cycle_count,
               expected_tallies.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 40) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
  endtask

  function automatic void clear_text_history();
    recent_text   = '0;
    text_fill     = 0;
    running_tally = '0;
  endfunction

  // Advance the predicted counter by one accepted request.
  function automatic void advance_counter(input poc_in_t req);
    logic [8*MAX_PAT-1:0] mask;
    poc_out_t             res;
    if (req.kind == KIND_PATTERN) begin
      // A pattern byte after a closed pattern starts a new case.
      if (pattern_closed) begin
        pattern_len      = 0;
        pattern_too_long = 1'b0;
        pattern_closed   = 1'b0;
        clear_text_history();
      end
      if (pattern_len < MAX_PAT) begin
        pattern_bytes = {pattern_bytes[8*MAX_PAT-9:0], req.symbol};
        pattern_len++;
      end else begin
        pattern_too_long = 1'b1;
      end
      if (req.last) begin
        pattern_closed = 1'b1;
      end
    end else begin
      pattern_closed = 1'b1;
      recent_text = {recent_text[8*MAX_PAT-9:0], req.symbol};
      if (text_fill < MAX_PAT) begin
        text_fill++;
      end
      // Compare the newest pattern_len text bytes with the pattern.
      mask = {(8*MAX_PAT){1'b1}} >> (8 * (MAX_PAT - pattern_len));
      if (!pattern_too_long && text_fill >= pattern_len &&
          ((recent_text ^ pattern_bytes) & mask) == '0 && running_tally != COUNT_TOP) begin
        running_tally++;
      end
      if (req.last) begin
        res.match_count      = pattern_too_long ? '0 : running_tally;
        res.pattern_overflow = pattern_too_long;
        expected_tallies.insert(expected_tallies.size(), res);
        clear_text_history();
      end
    end
  endfunction

  // Send one request; the sender idles between bursts unless held steady.
  task automatic put_byte(input logic kind, input logic [7:0] sym, input logic last);
    poc_in_t     req;
    int unsigned gap;
    req.kind   = kind;
    req.symbol = sym;
    req.last   = last;
    if (!steady && burst_left == 0) begin
      gap = $urandom_range(1, 6);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 100) : $urandom_range(1, 10);
    end
    if (burst_left != 0) begin
      burst_left--;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    advance_counter(req);
    items_sent++;
  endtask

  // Receiver: the ready pattern switches between four randomly chosen modes.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        ready_mode = rx_mode_e'($urandom_range(0, 3));
        mode_left  = $urandom_range(16, 160);
      end
      mode_left--;
      case (ready_mode)
        RX_OPEN:   ready_now = 1'b1;
        RX_MOSTLY: ready_now = ($urandom_range(0, 3) != 0);
        RX_SPARSE: ready_now = ($urandom_range(0, 3) == 0);
        default:   ready_now = ~out_ready;
      endcase
      out_ready <= !hold_off && (steady || ready_now);
    end
  end

  // Long receiver hold-off, counted here in clock cycles.
  initial begin
    hold_off = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off     = 1'b0;
        hold_request = 1'b0;
      end
    end
  end

  // Compare each accepted result with the oldest predicted count.
  always @(posedge clk) begin
    poc_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_tallies.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected: count %0d overflow %0b",
                                  out_data.match_count, out_data.pattern_overflow));
      end else begin
        want = expected_tallies.pop_front();
        if (out_data.match_count !== want.match_count) begin
          report_mismatch($sformatf("match_count %0d, expected %0d",
                                    out_data.match_count, want.match_count));
        end
        if (out_data.pattern_overflow !== want.pattern_overflow) begin
          report_mismatch($sformatf("pattern_overflow %0b, expected %0b",
                                    out_data.pattern_overflow, want.pattern_overflow));
        end
      end
    end
  end

  // Hand-picked cases; the first one relies on the state right after reset.
  task automatic test_directed_cases();
    // Text straight after reset closes an empty pattern, so every byte counts.
    put_byte(KIND_TEXT, 8'h00, 1'b0);
    put_byte(KIND_TEXT, 8'hFF, 1'b0);
    put_byte(KIND_TEXT, 8'h23, 1'b1);
    // The separator byte is ordinary; overlapping occurrences all count.
    put_byte(KIND_PATTERN, 8'h23, 1'b0);
    put_byte(KIND_PATTERN, 8'h23, 1'b1);
    put_byte(KIND_TEXT, 8'h23, 1'b0);
    put_byte(KIND_TEXT, 8'h23, 1'b0);
    put_byte(KIND_TEXT, 8'h23, 1'b1);
    // Extreme byte values, then a second text against the kept pattern.
    put_byte(KIND_PATTERN, 8'hFF, 1'b0);
    put_byte(KIND_PATTERN, 8'h00, 1'b1);
    put_byte(KIND_TEXT, 8'hFF, 1'b0);
    put_byte(KIND_TEXT, 8'h00, 1'b0);
    put_byte(KIND_TEXT, 8'hFF, 1'b0);
    put_byte(KIND_TEXT, 8'h00, 1'b1);
    put_byte(KIND_TEXT, 8'h00, 1'b0);
    put_byte(KIND_TEXT, 8'hFF, 1'b1);
    // A text byte closes a pattern that never saw last.
    put_byte(KIND_PATTERN, 8'h41, 1'b0);
    put_byte(KIND_TEXT, 8'h41, 1'b1);
    // A new pattern in the middle of a text drops the partial text.
    put_byte(KIND_PATTERN, 8'h5A, 1'b1);
    put_byte(KIND_TEXT, 8'h5A, 1'b0);
    put_byte(KIND_TEXT, 8'h5A, 1'b0);
    put_byte(KIND_PATTERN, 8'h42, 1'b1);
    put_byte(KIND_TEXT, 8'h42, 1'b1);
  endtask

  // A pattern that fills the whole row, then one byte longer.
  task automatic test_length_limits();
    logic [7:0] word [MAX_PAT];
    foreach (word[i]) word[i] = $urandom_range(0, 255);
    foreach (word[i]) put_byte(KIND_PATTERN, word[i], i == MAX_PAT - 1);
    put_byte(KIND_TEXT, 8'h00, 1'b0);
    foreach (word[i]) put_byte(KIND_TEXT, word[i], i == MAX_PAT - 1);
    foreach (word[i]) put_byte(KIND_PATTERN, word[i], 1'b0);
    put_byte(KIND_PATTERN, 8'hFF, 1'b1);
    foreach (word[i]) put_byte(KIND_TEXT, word[i], i == MAX_PAT - 1);
  endtask

  // One-byte pattern against a text that matches at every byte, at full rate.
  task automatic test_dense_matches();
    steady = 1'b1;
    put_byte(KIND_PATTERN, 8'h55, 1'b1);
    for (int i = 0; i < DENSE_RUN; i++) begin
      put_byte(KIND_TEXT, 8'h55, i == DENSE_RUN - 1);
    end
    steady = 1'b0;
  endtask

  // Short texts while the receiver holds off, so the block stalls its input.
  task automatic test_output_backpressure();
    steady       = 1'b1;
    hold_request = 1'b1;
    put_byte(KIND_PATTERN, 8'hC3, 1'b1);
    for (int i = 0; i < 40; i++) begin
      put_byte(KIND_TEXT, (i % 3 == 0) ? 8'hC3 : 8'h3C, 1'b1);
    end
    steady = 1'b0;
  endtask

  function automatic logic [7:0] draw_symbol(input logic [7:0] base, input int unsigned span);
    if ($urandom_range(0, 19) == 0) begin
      return 8'($urandom_range(0, 255));
    end
    return base + 8'($urandom_range(0, span - 1));
  endfunction

  // Random cases over a small alphabet so that matches are frequent.
  task automatic test_random_streams();
    int unsigned stop_at;
    int unsigned pick;
    int unsigned plen;
    int unsigned tlen;
    int unsigned texts;
    int unsigned span;
    logic [7:0]  base;
    bit          closed;
    stop_at = items_sent + RANDOM_ITEMS;
    while (items_sent < stop_at) begin
      base  = $urandom_range(0, 255);
      span  = $urandom_range(1, 3);
      pick  = $urandom_range(0, 99);
      plen  = (pick < 80) ? $urandom_range(1, 4) :
              (pick < 93) ? $urandom_range(5, 20) : $urandom_range(60, 70);
      // Now and then the pattern ends without last and the text closes it.
      closed = ($urandom_range(0, 9) != 0);
      for (int i = 0; i < plen; i++) begin
        put_byte(KIND_PATTERN, draw_symbol(base, span), closed && i == plen - 1);
      end
      texts = $urandom_range(1, 3);
      for (int t = 0; t < texts; t++) begin
        tlen = $urandom_range(1, 30) + ((plen > 20) ? plen : 0);
        // Some texts break off without last; a following pattern drops them.
        closed = ($urandom_range(0, 11) != 0);
        for (int i = 0; i < tlen; i++) begin
          put_byte(KIND_TEXT, draw_symbol(base, span), closed && i == tlen - 1);
        end
      end
    end
  endtask

  // Test sequence.
  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_length_limits();
    test_dense_matches();
    test_output_backpressure();
    test_random_streams();

    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_tallies.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
